[sv/tes_pkg.sv]
package tes_pkg;

	// Default sizes of the block.
	localparam int MAX_RADIUS_DEF = 7;
	localparam int MAX_WIDTH_DEF  = 2048;
	localparam int PIXEL_BITS_DEF = 16;

	// Configuration register widths.
	localparam int FW_BITS  = 12;
	localparam int FH_BITS  = 16;
	localparam int FR_BITS  = 3;
	localparam int CFG_BITS = 16;
	localparam int CFG_IDX_BITS = 2;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_FRAME_WIDTH   = 2'd0,
		REG_FRAME_HEIGHT  = 2'd1,
		REG_WINDOW_RADIUS = 2'd2
	} cfg_reg_t;

	// Controls shared by every line-delay cell.
	typedef struct packed {
		logic push;
		logic bypass;
	} row_ctrl_t;

endpackage

[sv/toward_extreme_sharpen.sv]
// A result is due when the item that completes its window is accepted (R rows plus R pixels
// after its centre pixel entered); its tag then passes tok_s1 to tok_s6 and the output queue.
// Throughput: one item per cycle, set by the single write port of each line-delay cell
// and the fixed min/max trees; m_tready low fills a small output queue before s_tready drops.
// Reset: arst_n clears positions, counts, queue and registers to their reset values at once;
// the line stores are not cleared and are read only after they are written.
module toward_extreme_sharpen
	import tes_pkg::*;
#(
	parameter int MAX_RADIUS = MAX_RADIUS_DEF,
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int PIXEL_BITS = PIXEL_BITS_DEF,
	localparam int DB = ((PIXEL_BITS + 7) / 8) * 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [CFG_BITS-1:0]     cfg_data,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	input  logic [DB-1:0]           s_tdata,   // pixel_in
	input  logic                    s_tuser,   // flush
	output logic                    m_tvalid,
	input  logic                    m_tready,
	output logic [DB-1:0]           m_tdata,   // pixel_out
	output logic                    m_tlast    // end_of_frame
);

	localparam int PB   = PIXEL_BITS;
	localparam int N    = 2 * MAX_RADIUS + 1;
	localparam int NROW = 2 * MAX_RADIUS;
	localparam int IW   = $clog2(N);
	localparam int WB   = $clog2(MAX_WIDTH + 1);
	localparam int RB   = $clog2(MAX_RADIUS + 1);
	localparam int AW   = $clog2(MAX_WIDTH);
	localparam int D    = (2 * MAX_RADIUS + 2) * MAX_WIDTH;
	localparam int DAW  = $clog2(D);
	localparam int PCB  = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 2);
	localparam int FIFO_DEPTH = 10;
	localparam int CRB  = $clog2(FIFO_DEPTH + 1);

	typedef struct packed {
		logic          emit;
		logic          push;
		logic          interior;
		logic          eof;
		logic          byp;
		logic [PB-1:0] centre;
	} token_t;

	logic [FW_BITS-1:0] fw_q;
	logic [FH_BITS-1:0] fh_q;
	logic [FR_BITS-1:0] fr_q;
	logic [WB-1:0]      eff_w;
	logic [FH_BITS-1:0] eff_h;
	logic [RB-1:0]      eff_r;
	logic [PCB-1:0]     thresh;
	logic [IW-1:0]      last_idx;

	logic [FH_BITS-1:0] in_row_q;
	logic [WB-1:0]      in_col_q;
	logic [FH_BITS-1:0] out_row_q;
	logic [WB-1:0]      out_col_q;
	logic [PCB-1:0]     pending_q;
	logic [DAW-1:0]     wp_q;
	logic [AW-1:0]      ptr_q;
	logic [CRB-1:0]     credit_q;

	logic               acc;
	logic               push;
	logic               emit;
	logic               in_origin;
	logic               interior;
	logic               eof;
	logic [DAW:0]       rd_x;
	logic [DAW-1:0]     rd_addr;
	logic [PB-1:0]      pix;

	logic [PB-1:0]      cmem [D];
	logic [PB-1:0]      centre_s1;
	row_ctrl_t          row_ctrl;
	logic [PB-1:0]      col [N];
	logic [PB-1:0]      col_s1 [N];
	logic [PB-1:0]      col_lo;
	logic [PB-1:0]      col_hi;
	logic [PB-1:0]      hlo_q [N];
	logic [PB-1:0]      hhi_q [N];
	logic [PB-1:0]      win_lo;
	logic [PB-1:0]      win_hi;

	token_t             tok_s1, tok_s2, tok_s3, tok_s4, tok_s5, tok_s6;
	logic [PB-1:0]      diff_lo;
	logic [PB-1:0]      diff_hi;
	logic [PB-1:0]      result;
	logic [PB:0]        fifo_rd;
	logic               pop;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q <= FW_BITS'(2048);
			fh_q <= FH_BITS'(1024);
			fr_q <= FR_BITS'(1);
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_FRAME_WIDTH:   fw_q <= cfg_data[FW_BITS-1:0];
				REG_FRAME_HEIGHT:  fh_q <= cfg_data[FH_BITS-1:0];
				REG_WINDOW_RADIUS: fr_q <= cfg_data[FR_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Effective geometry with the register values clamped to the supported range.
	always_comb begin
		if (fw_q == '0) begin
			eff_w = WB'(1);
		end else if (32'(fw_q) > 32'(MAX_WIDTH)) begin
			eff_w = WB'(MAX_WIDTH);
		end else begin
			eff_w = WB'(fw_q);
		end
		eff_h = (fh_q == '0) ? FH_BITS'(1) : fh_q;
		if (32'(fr_q) > 32'(MAX_RADIUS)) begin
			eff_r = RB'(MAX_RADIUS);
		end else begin
			eff_r = RB'(fr_q);
		end
		thresh   = PCB'(32'(eff_r) * 32'(eff_w) + 32'(eff_r));
		last_idx = IW'(32'(eff_r) * 2);
	end

	// Accept and result decision.
	assign s_tready  = (credit_q < CRB'(FIFO_DEPTH));
	assign acc       = s_tvalid && s_tready;
	assign push      = acc && !s_tuser;
	assign pix       = s_tdata[PB-1:0];
	assign in_origin = (in_row_q == '0) && (in_col_q == '0);

	always_comb begin
		if (s_tuser) begin
			emit = acc && (pending_q != '0) && in_origin;
		end else begin
			emit = acc && (({1'b0, pending_q} + (PCB + 1)'(1)) > {1'b0, thresh});
		end
	end

	// Address of the centre pixel in the circular store.
	always_comb begin
		if ({1'b0, wp_q} >= (DAW + 1)'(pending_q)) begin
			rd_x = {1'b0, wp_q} - (DAW + 1)'(pending_q);
		end else begin
			rd_x = {1'b0, wp_q} + (DAW + 1)'(D) - (DAW + 1)'(pending_q);
		end
		rd_addr = rd_x[DAW-1:0];
	end

	// Border test and end of frame for the next output position.
	always_comb begin
		interior = (32'(out_col_q) >= 32'(eff_r)) &&
			(32'(out_col_q) + 32'(eff_r) <= 32'(eff_w) - 32'd1) &&
			(32'(out_row_q) >= 32'(eff_r)) &&
			(32'(out_row_q) + 32'(eff_r) <= 32'(eff_h) - 32'd1);
		eof = (32'(out_row_q) == 32'(eff_h) - 32'd1) &&
			(32'(out_col_q) == 32'(eff_w) - 32'd1);
	end

	// Positions, counts and pointers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_row_q  <= '0;
			in_col_q  <= '0;
			out_row_q <= '0;
			out_col_q <= '0;
			pending_q <= '0;
			wp_q      <= '0;
			ptr_q     <= '0;
		end else begin
			if (push) begin
				if (({1'b0, in_col_q} + (WB + 1)'(1)) >= {1'b0, eff_w}) begin
					in_col_q <= '0;
					if (({1'b0, in_row_q} + (FH_BITS + 1)'(1)) >= {1'b0, eff_h}) begin
						in_row_q <= '0;
					end else begin
						in_row_q <= in_row_q + FH_BITS'(1);
					end
				end else begin
					in_col_q <= in_col_q + WB'(1);
				end
				wp_q <= (wp_q == DAW'(D - 1)) ? '0 : wp_q + DAW'(1);
			end
			// A new row width restarts the line-delay address inside the new range.
			if (cfg_we && (cfg_reg_t'(cfg_index) == REG_FRAME_WIDTH)) begin
				ptr_q <= '0;
			end else if (push) begin
				if (32'(ptr_q) + 32'd2 >= 32'(eff_w)) begin
					ptr_q <= '0;
				end else begin
					ptr_q <= ptr_q + AW'(1);
				end
			end
			if (emit) begin
				if (({1'b0, out_col_q} + (WB + 1)'(1)) >= {1'b0, eff_w}) begin
					out_col_q <= '0;
					if (({1'b0, out_row_q} + (FH_BITS + 1)'(1)) >= {1'b0, eff_h}) begin
						out_row_q <= '0;
					end else begin
						out_row_q <= out_row_q + FH_BITS'(1);
					end
				end else begin
					out_col_q <= out_col_q + WB'(1);
				end
			end
			pending_q <= pending_q + PCB'(push) - PCB'(emit);
		end
	end

	// Circular centre store, registered read.
	always_ff @(posedge clk) begin
		if (push) begin
			cmem[wp_q] <= pix;
		end
		centre_s1 <= cmem[rd_addr];
	end

	// Chain of line-delay cells: tap k is the pixel k rows back.
	assign row_ctrl.push   = push;
	assign row_ctrl.bypass = (eff_w == WB'(1));
	assign col[0]          = pix;

	for (genvar k = 0; k < NROW; k++) begin : g_row
		tes_row_cell #(
			.DEPTH (MAX_WIDTH),
			.PB    (PB)
		) u_row (
			.clk  (clk),
			.ctrl (row_ctrl),
			.addr (ptr_q),
			.din  (col[k]),
			.dout (col[k+1])
		);
	end

	always_ff @(posedge clk) begin
		col_s1 <= col;
	end

	// Column extremes of the newest window column.
	tes_minmax #(
		.N  (N),
		.PB (PB)
	) u_col (
		.clk      (clk),
		.last_idx (last_idx),
		.lo_in    (col_s1),
		.hi_in    (col_s1),
		.lo_out   (col_lo),
		.hi_out   (col_hi)
	);

	// Row of window cells: column extremes step one place per stored pixel.
	always_ff @(posedge clk) begin
		if (tok_s3.push) begin
			hlo_q[0] <= col_lo;
			hhi_q[0] <= col_hi;
			for (int i = 1; i < N; i++) begin
				hlo_q[i] <= hlo_q[i-1];
				hhi_q[i] <= hhi_q[i-1];
			end
		end
	end

	// Window extremes across the active columns.
	tes_minmax #(
		.N  (N),
		.PB (PB)
	) u_win (
		.clk      (clk),
		.last_idx (last_idx),
		.lo_in    (hlo_q),
		.hi_in    (hhi_q),
		.lo_out   (win_lo),
		.hi_out   (win_hi)
	);

	// Item tags travel beside the data path.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s1 <= '0;
			tok_s2 <= '0;
			tok_s3 <= '0;
			tok_s4 <= '0;
			tok_s5 <= '0;
			tok_s6 <= '0;
		end else begin
			tok_s1 <= '{emit: emit, push: push, interior: interior, eof: eof,
				byp: push && (rd_addr == wp_q), centre: pix};
			tok_s2 <= '{emit: tok_s1.emit, push: tok_s1.push, interior: tok_s1.interior,
				eof: tok_s1.eof, byp: tok_s1.byp,
				centre: tok_s1.byp ? tok_s1.centre : centre_s1};
			tok_s3 <= tok_s2;
			tok_s4 <= tok_s3;
			tok_s5 <= tok_s4;
			tok_s6 <= tok_s5;
		end
	end

	// Pick the nearer extreme; border pixels pass through.
	always_comb begin
		diff_lo = tok_s6.centre - win_lo;
		diff_hi = win_hi - tok_s6.centre;
		if (!tok_s6.interior) begin
			result = tok_s6.centre;
		end else if (diff_lo <= diff_hi) begin
			result = win_lo;
		end else begin
			result = win_hi;
		end
	end

	tes_out_fifo #(
		.DEPTH (FIFO_DEPTH),
		.W     (PB + 1)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (tok_s6.emit),
		.wr_data   ({tok_s6.eof, result}),
		.rd_en     (m_tready),
		.rd_data   (fifo_rd),
		.not_empty (m_tvalid)
	);

	assign pop     = m_tvalid && m_tready;
	assign m_tdata = DB'(fifo_rd[PB-1:0]);
	assign m_tlast = fifo_rd[PB];

	// Credits: results promised by accepted items and not yet taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
		end else begin
			credit_q <= credit_q + CRB'(emit) - CRB'(pop);
		end
	end

	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		credit_q <= CRB'(FIFO_DEPTH))
		else $error("credit count above queue depth");

	a_out_has_credit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (credit_q != '0))
		else $error("result offered without a credit");

	a_write_has_credit: assert property (@(posedge clk) disable iff (!arst_n)
		tok_s6.emit |-> (credit_q != '0))
		else $error("queue write without a credit");

	a_push_tagged: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && !s_tuser) |=> tok_s1.push)
		else $error("stored pixel lost its tag");

endmodule

[sv/tes_row_cell.sv]
module tes_row_cell
	import tes_pkg::*;
#(
	parameter int DEPTH = MAX_WIDTH_DEF,
	parameter int PB    = PIXEL_BITS_DEF,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic          clk,
	input  row_ctrl_t     ctrl,
	input  logic [AW-1:0] addr,
	input  logic [PB-1:0] din,
	output logic [PB-1:0] dout
);

	logic [PB-1:0] mem [DEPTH];
	logic [PB-1:0] dout_q;

	// One image row of delay: w-1 entries in the memory plus the output register.
	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			mem[addr] <= din;
			if (ctrl.bypass) begin
				dout_q <= din;
			end else begin
				dout_q <= mem[addr];
			end
		end
	end

	assign dout = dout_q;

endmodule

[sv/tes_minmax.sv]
module tes_minmax
	import tes_pkg::*;
#(
	parameter int N  = 2 * MAX_RADIUS_DEF + 1,
	parameter int PB = PIXEL_BITS_DEF,
	localparam int IW = $clog2(N)
) (
	input  logic          clk,
	input  logic [IW-1:0] last_idx,
	input  logic [PB-1:0] lo_in [N],
	input  logic [PB-1:0] hi_in [N],
	output logic [PB-1:0] lo_out,
	output logic [PB-1:0] hi_out
);

	localparam int G = (N + 3) / 4;

	logic [PB-1:0] glo [G];
	logic [PB-1:0] ghi [G];
	logic [PB-1:0] glo_s1 [G];
	logic [PB-1:0] ghi_s1 [G];
	logic [PB-1:0] flo;
	logic [PB-1:0] fhi;
	logic [PB-1:0] lo_s2;
	logic [PB-1:0] hi_s2;

	// First level: minimum and maximum of each group of four active entries.
	always_comb begin
		for (int g = 0; g < G; g++) begin
			glo[g] = '1;
			ghi[g] = '0;
			for (int j = 0; j < 4; j++) begin
				if ((g * 4 + j) < N) begin
					if ((g * 4 + j) <= int'(last_idx)) begin
						if (lo_in[(g * 4 + j) % N] < glo[g]) glo[g] = lo_in[(g * 4 + j) % N];
						if (hi_in[(g * 4 + j) % N] > ghi[g]) ghi[g] = hi_in[(g * 4 + j) % N];
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		glo_s1 <= glo;
		ghi_s1 <= ghi;
	end

	// Second level: across the groups.
	always_comb begin
		flo = '1;
		fhi = '0;
		for (int g = 0; g < G; g++) begin
			if (glo_s1[g] < flo) flo = glo_s1[g];
			if (ghi_s1[g] > fhi) fhi = ghi_s1[g];
		end
	end

	always_ff @(posedge clk) begin
		lo_s2 <= flo;
		hi_s2 <= fhi;
	end

	assign lo_out = lo_s2;
	assign hi_out = hi_s2;

endmodule

[sv/tes_out_fifo.sv]
module tes_out_fifo
	import tes_pkg::*;
#(
	parameter int DEPTH = 10,
	parameter int W     = PIXEL_BITS_DEF + 1
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr_en,
	input  logic [W-1:0] wr_data,
	input  logic         rd_en,
	output logic [W-1:0] rd_data,
	output logic         not_empty
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [PW-1:0] wp_q;
	logic [PW-1:0] rp_q;
	logic [CW-1:0] cnt_q;
	logic          do_rd;

	assign do_rd = rd_en && (cnt_q != '0);

	// Storage for finished items.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wp_q] <= wr_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) begin
				wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + PW'(1);
			end
			if (do_rd) begin
				rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + PW'(1);
			end
			cnt_q <= cnt_q + CW'(wr_en) - CW'(do_rd);
		end
	end

	assign rd_data   = mem_q[rp_q];
	assign not_empty = (cnt_q != '0);

endmodule

[test/tb_top.sv]
module tb_top;
	import tes_pkg::*;

	localparam int STORE_DEPTH = (2 * MAX_RADIUS_DEF + 2) * MAX_WIDTH_DEF;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int TAIL_CYCLES = 30;

	typedef struct {
		logic [15:0] pixel;
		logic        last;
	} sharp_pixel_t;

	typedef enum logic [1:0] {ROW_REG, ROW_TYPED, ROW_PREDICT} row_kind_t;

	typedef struct {
		row_kind_t   kind;
		int          reg_val;
		logic        flush;
		logic [15:0] pixel;
		logic        has_result;
		logic [15:0] res_pixel;
		logic        res_last;
		cfg_reg_t    reg_idx;
	} stim_row_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    cfg_we = 1'b0;
	logic [CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [CFG_BITS-1:0]     cfg_data = '0;
	logic                    s_tvalid = 1'b0;
	logic                    s_tready;
	logic [15:0]             s_tdata = '0;   // pixel_in
	logic                    s_tuser = 1'b0; // flush
	logic                    m_tvalid;
	logic                    m_tready = 1'b1;
	logic [15:0]             m_tdata;        // pixel_out
	logic                    m_tlast;        // end_of_frame

	toward_extreme_sharpen i_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.s_tdata(s_tdata), .s_tuser(s_tuser), .m_tvalid(m_tvalid),
		.m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	always #5 clk = ~clk;

	// Predictor state of the sharpening pipeline.
	logic [15:0]  pix_store [STORE_DEPTH];
	int unsigned  p_width = 2048, p_height = 1024, p_radius = 1;
	int unsigned  p_in_row, p_in_col, p_out_row, p_out_col, p_wr_ptr, p_pending;
	sharp_pixel_t sharpened_q[$];
	int           mismatches = 0;
	int           cycles = 0;
	int           items_sent = 0;
	bit           burst = 0;
	int           rx_stall = 0;

	function automatic int unsigned eff_w();
		return (p_width < 1) ? 1 : ((p_width > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : p_width);
	endfunction

	function automatic int unsigned eff_h();
		return (p_height < 1) ? 1 : p_height;
	endfunction

	function automatic int unsigned eff_r();
		return (p_radius > MAX_RADIUS_DEF) ? MAX_RADIUS_DEF : p_radius;
	endfunction

	function automatic logic [15:0] store_at(int unsigned base, int off);
		int a;
		a = ((int'(base) + off) % STORE_DEPTH + STORE_DEPTH) % STORE_DEPTH;
		return pix_store[a];
	endfunction

	task automatic step_pos(inout int unsigned row, inout int unsigned col);
		if (col + 1 >= eff_w()) begin
			col = 0;
			row = (row + 1 >= eff_h()) ? 0 : row + 1;
		end else begin
			col = col + 1;
		end
	endtask

	// Produce the output for the oldest pending centre pixel.
	task automatic emit_sharpened(output sharp_pixel_t res);
		int unsigned w, h, r, q, centre, lo, hi, v;
		w = eff_w();
		h = eff_h();
		r = eff_r();
		q = (p_wr_ptr + STORE_DEPTH - p_pending) % STORE_DEPTH;
		centre = 32'(store_at(q, 0));
		res.pixel = 16'(centre);
		if (p_out_col >= r && p_out_col + r <= w - 1 && p_out_row >= r &&
				p_out_row + r <= h - 1) begin
			lo = 32'h0000ffff;
			hi = 0;
			for (int dr = -int'(r); dr <= int'(r); dr++) begin
				for (int dc = -int'(r); dc <= int'(r); dc++) begin
					v = 32'(store_at(q, dr * int'(w) + dc));
					if (v < lo) lo = v;
					if (v > hi) hi = v;
				end
			end
			res.pixel = 16'((centre - lo <= hi - centre) ? lo : hi);
		end
		res.last = (p_out_row == h - 1 && p_out_col == w - 1);
		step_pos(p_out_row, p_out_col);
		p_pending--;
	endtask

	// Advance the predictor by one accepted item; returns 1 when a result follows.
	task automatic predict_item(input logic flush, input logic [15:0] pix,
			output bit got, output sharp_pixel_t res);
		got = 0;
		if (flush) begin
			if (p_pending > 0 && p_in_row == 0 && p_in_col == 0) begin
				emit_sharpened(res);
				got = 1;
			end
		end else begin
			pix_store[p_wr_ptr] = pix;
			p_wr_ptr = (p_wr_ptr + 1) % STORE_DEPTH;
			p_pending++;
			step_pos(p_in_row, p_in_col);
			if (p_pending > eff_r() * eff_w() + eff_r()) begin
				emit_sharpened(res);
				got = 1;
			end
		end
	endtask

	// Send one item, after a random gap unless in burst mode; the predictor follows on acceptance.
	task automatic send_item(input logic flush, input logic [15:0] pix,
			input bit typed, input bit t_has, input sharp_pixel_t t_res);
		int gap;
		bit got;
		sharp_pixel_t res;
		gap = burst ? 0 : int'($urandom_range(0, 10));
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= pix;
		s_tuser <= flush;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_item(flush, pix, got, res);
		if (typed) begin
			got = t_has;
			res = t_res;
		end
		if (got) sharpened_q.push_back(res);
		items_sent++;
	endtask

	task automatic wait_results();
		s_tvalid <= 1'b0;
		while (sharpened_q.size() != 0) @(posedge clk);
	endtask

	// Registers are to change only with the pipeline empty and settled; this task does not enforce it.
	task automatic write_reg(input cfg_reg_t idx, input int val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_BITS'(val);
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_FRAME_WIDTH:   p_width = val & 12'hfff;
			REG_FRAME_HEIGHT:  p_height = val & 16'hffff;
			REG_WINDOW_RADIUS: p_radius = val & 3'h7;
			default: ;
		endcase
	endtask

	task automatic set_frame(input int w, input int h, input int r);
		wait_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		write_reg(REG_FRAME_WIDTH, w);
		write_reg(REG_FRAME_HEIGHT, h);
		write_reg(REG_WINDOW_RADIUS, r);
	endtask

	function automatic logic [15:0] rand_pixel();
		case ($urandom_range(0, 7))
			0: return 16'h0000;
			1: return 16'hffff;
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	// Send whole frames with some stray flushes, then drain the tail.
	task automatic run_frames(input int frames, input int noise_pct);
		sharp_pixel_t none;
		none = '{default: '0};
		for (int n = 0; n < frames * eff_w() * eff_h(); n++) begin
			if ($urandom_range(0, 99) < noise_pct) send_item(1'b1, rand_pixel(), 0, 0, none);
			send_item(1'b0, rand_pixel(), 0, 0, none);
		end
		while (p_pending > 0) send_item(1'b1, rand_pixel(), 0, 0, none);
	endtask

	// Check each accepted result against the oldest expectation.
	always @(posedge clk) begin
		sharp_pixel_t e;
		if (m_tvalid && m_tready) begin
			if (sharpened_q.size() == 0) begin
				if (mismatches < 10) $display("unexpected result pixel %h last %b", m_tdata, m_tlast);
				mismatches++;
			end else begin
				e = sharpened_q.pop_front();
				if (m_tdata !== e.pixel || m_tlast !== e.last) begin
					if (mismatches < 10)
						$display("result mismatch: expected pixel %h last %b, got pixel %h last %b",
							e.pixel, e.last, m_tdata, m_tlast);
					mismatches++;
				end
			end
			rx_stall = burst ? 0 : int'($urandom_range(0, 10));
			if (rx_stall > 0) m_tready <= 1'b0;
		end else if (!m_tready) begin
			if (rx_stall > 0) rx_stall--;
			if (rx_stall == 0) m_tready <= 1'b1;
		end
	end

	// Run limit.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Directed table: a unity window with typed results, then one 3x3 window.
	stim_row_t dir_rows[] = '{
		'{ROW_REG, 4, 0, 0, 0, 0, 0, REG_FRAME_WIDTH},
		'{ROW_REG, 2, 0, 0, 0, 0, 0, REG_FRAME_HEIGHT},
		'{ROW_REG, 0, 0, 0, 0, 0, 0, REG_WINDOW_RADIUS},
		'{ROW_TYPED, 0, 0, 16'h0000, 1, 16'h0000, 0, REG_FRAME_WIDTH},
		'{ROW_TYPED, 0, 0, 16'hffff, 1, 16'hffff, 0, REG_FRAME_WIDTH},
		'{ROW_TYPED, 0, 0, 16'h8000, 1, 16'h8000, 0, REG_FRAME_WIDTH},
		'{ROW_TYPED, 0, 1, 16'h1234, 0, 16'h0000, 0, REG_FRAME_WIDTH},
		'{ROW_TYPED, 0, 0, 16'h7fff, 1, 16'h7fff, 0, REG_FRAME_WIDTH},
		'{ROW_TYPED, 0, 0, 16'h0001, 1, 16'h0001, 0, REG_FRAME_WIDTH},
		'{ROW_TYPED, 0, 0, 16'haaaa, 1, 16'haaaa, 0, REG_FRAME_WIDTH},
		'{ROW_TYPED, 0, 0, 16'h5555, 1, 16'h5555, 0, REG_FRAME_WIDTH},
		'{ROW_TYPED, 0, 0, 16'hfffe, 1, 16'hfffe, 1, REG_FRAME_WIDTH},
		'{ROW_TYPED, 0, 1, 16'hffff, 0, 16'h0000, 0, REG_FRAME_WIDTH},
		'{ROW_REG, 3, 0, 0, 0, 0, 0, REG_FRAME_WIDTH},
		'{ROW_REG, 3, 0, 0, 0, 0, 0, REG_FRAME_HEIGHT},
		'{ROW_REG, 1, 0, 0, 0, 0, 0, REG_WINDOW_RADIUS},
		'{ROW_PREDICT, 0, 0, 16'h0000, 0, 0, 0, REG_FRAME_WIDTH},
		'{ROW_PREDICT, 0, 0, 16'hffff, 0, 0, 0, REG_FRAME_WIDTH},
		'{ROW_PREDICT, 0, 0, 16'h0010, 0, 0, 0, REG_FRAME_WIDTH},
		'{ROW_PREDICT, 0, 0, 16'h8000, 0, 0, 0, REG_FRAME_WIDTH},
		'{ROW_PREDICT, 0, 0, 16'h6000, 0, 0, 0, REG_FRAME_WIDTH},
		'{ROW_PREDICT, 0, 0, 16'h0100, 0, 0, 0, REG_FRAME_WIDTH},
		'{ROW_PREDICT, 0, 0, 16'h9000, 0, 0, 0, REG_FRAME_WIDTH},
		'{ROW_PREDICT, 0, 0, 16'h0002, 0, 0, 0, REG_FRAME_WIDTH},
		'{ROW_PREDICT, 0, 0, 16'hfff0, 0, 0, 0, REG_FRAME_WIDTH}
	};

	initial begin
		sharp_pixel_t typed_res;
		sharp_pixel_t none;
		int w, h, r;
		none = '{default: '0};
		p_in_row = 0; p_in_col = 0; p_out_row = 0; p_out_col = 0;
		p_wr_ptr = 0; p_pending = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed part.
		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_REG) begin
				wait_results();
				repeat (TAIL_CYCLES) @(posedge clk);
				write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
			end else begin
				typed_res.pixel = dir_rows[i].res_pixel;
				typed_res.last = dir_rows[i].res_last;
				send_item(dir_rows[i].flush, dir_rows[i].pixel, dir_rows[i].kind == ROW_TYPED,
					dir_rows[i].has_result, typed_res);
			end
		end
		while (p_pending > 0) send_item(1'b1, 16'h0000, 0, 0, none);

		// Zero width and height act as a single pixel.
		set_frame(0, 0, 5);
		run_frames(12, 20);

		// Random phases of small frames.
		while (items_sent < 1660) begin
			burst = ($urandom_range(0, 3) == 0);
			w = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 24) : $urandom_range(1, 10);
			h = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 20) : $urandom_range(1, 8);
			r = $urandom_range(0, 7);
			if ($urandom_range(0, 2) != 0 && r > 3) r = $urandom_range(1, 3);
			set_frame(w, h, r);
			run_frames($urandom_range(1, 3), 5);
			// At random, hold the sender until the output side has caught up.
			if ($urandom_range(0, 4) == 0) wait_results();
		end
		burst = 0;

		// Tallest frame register with a unity window; the frame is left open.
		set_frame(1, 65535, 0);
		for (int n = 0; n < 40; n++) send_item($urandom_range(0, 4) == 0, rand_pixel(), 0, 0, none);

		wait_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && sharpened_q.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
